// ===== rtl/core/nrp_pkg.sv =====
// package for the reader ack and response parser
// holds item and result types, event codes and frame constants; no dependencies
package nrp_pkg;

  localparam int unsigned BUFFER_BYTES = 64;
  localparam int unsigned HELD_W       = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned POS_W        = $clog2(BUFFER_BYTES);
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned WIN_W        = 40;

  localparam logic [WIN_W-1:0] ACK_HEAD    = 40'h00_00FF_00FF;
  localparam logic [7:0]       ACK_TAIL    = 8'h00;
  localparam logic [7:0]       START_BYTE  = 8'h00;
  localparam logic [7:0]       START_CODE  = 8'hFF;
  localparam logic [7:0]       DIR_TO_HOST = 8'hD5;
  localparam logic [2:0]       WIN_FULL    = 3'd5;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [2:0] {
    EV_CONSUMED = 3'd0,
    EV_ACK      = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_GOOD     = 3'd3,
    EV_BAD      = 3'd4,
    EV_DROPPED  = 3'd5
  } event_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_e           event_res;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] data_index;
    logic [7:0]       response_command;
    logic [IDX_W-1:0] response_length;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } in_link_t;

endpackage

// ===== rtl/core/nrp_in_stage.sv =====
// input register of the parser
// depends on nrp_pkg
module nrp_in_stage
  import nrp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  item_t    item_i,
  output in_link_t link_o,
  input  logic     take_i
);

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign link_o  = '{valid: valid_q, item: item_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/core/nrp_parser.sv =====
// per-byte state update of the parser and its result register
// depends on nrp_pkg
module nrp_parser
  import nrp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_link_t link_i,
  output logic     take_o,
  output logic     valid_o,
  input  logic     ready_i,
  output result_t  result_o
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_FRAME = 2'd1,
    PH_DONE  = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [2:0]        fill_q, fill_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        cmd_q, cmd_d;
  logic              out_v_q;
  result_t           out_q, res;

  assign take_o   = link_i.valid && (!out_v_q || ready_i);
  assign valid_o  = out_v_q;
  assign result_o = out_q;

  always_comb begin
    logic [7:0] b;
    logic [8:0] pos_w;
    logic [7:0] sum_add;
    logic [7:0] lcs_sum;
    b       = link_i.item.rx_byte;
    pos_w   = 9'(pos_q);
    sum_add = sum_q + b;
    lcs_sum = len_q + b;
    phase_d = phase_q;
    win_d   = win_q;
    fill_d  = fill_q;
    held_d  = held_q;
    pos_d   = pos_q;
    len_d   = len_q;
    sum_d   = sum_q;
    cmd_d   = cmd_q;
    res     = '{event_res: EV_CONSUMED, default: '0};
    if (link_i.item.opcode == OP_RESTART) begin
      phase_d = PH_HUNT;
      win_d   = '0;
      fill_d  = '0;
      held_d  = '0;
      pos_d   = '0;
      len_d   = '0;
      sum_d   = '0;
      cmd_d   = '0;
    end else if (held_q >= HELD_W'(BUFFER_BYTES)) begin
      res.event_res = EV_DROPPED;
    end else begin
      held_d = held_q + 1'b1;
      unique case (phase_q)
        PH_HUNT: begin
          if (fill_q >= WIN_FULL && win_q == ACK_HEAD && b == ACK_TAIL) begin
            res.event_res = EV_ACK;
            phase_d       = PH_FRAME;
            pos_d         = '0;
          end
          win_d = {win_q[WIN_W-9:0], b};
          if (fill_q < WIN_FULL) begin
            fill_d = fill_q + 1'b1;
          end
        end
        PH_FRAME: begin
          pos_d = pos_q + 1'b1;
          if (pos_w == 9'd0 || pos_w == 9'd1) begin
            if (b != START_BYTE) res.event_res = EV_BAD;
          end else if (pos_w == 9'd2) begin
            if (b != START_CODE) res.event_res = EV_BAD;
          end else if (pos_w == 9'd3) begin
            len_d = b;
          end else if (pos_w == 9'd4) begin
            if (lcs_sum != 8'h00) res.event_res = EV_BAD;
          end else if (pos_w == 9'd5) begin
            if (b != DIR_TO_HOST) begin
              res.event_res = EV_BAD;
            end else begin
              sum_d = b;
            end
          end else if (pos_w == {1'b0, len_q} + 9'd6) begin
            if (len_q >= 8'd2 && sum_q == 8'h00) begin
              res.event_res       = EV_GOOD;
              res.response_length = IDX_W'(len_q - 8'd2);
            end else begin
              res.event_res = EV_BAD;
            end
          end else if (pos_w == {1'b0, len_q} + 9'd5) begin
            sum_d = sum_add;
          end else begin
            sum_d = sum_add;
            if (pos_w == 9'd6) begin
              cmd_d = b;
            end else begin
              res.event_res  = EV_PAYLOAD;
              res.data_byte  = b;
              res.data_index = IDX_W'(pos_w - 9'd7);
            end
          end
          if (res.event_res == EV_GOOD || res.event_res == EV_BAD) begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
    res.response_command = cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      win_q   <= '0;
      fill_q  <= '0;
      held_q  <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      cmd_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (take_o) begin
        phase_q <= phase_d;
        win_q   <= win_d;
        fill_q  <= fill_d;
        held_q  <= held_d;
        pos_q   <= pos_d;
        len_q   <= len_d;
        sum_q   <= sum_d;
        cmd_q   <= cmd_d;
        out_v_q <= 1'b1;
      end else if (ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= res;
    end
  end

endmodule

// ===== rtl/core/nfc_reader_ack_and_response_parser_top.sv =====
// top level of the reader ack and response parser
// depends on nrp_pkg, nrp_in_stage and nrp_parser
//
// Takes one received byte or a restart per item, finds the acknowledge
// pattern 00 00 FF 00 FF 00, then checks the response frame that follows
// (start code, length checksum, direction byte D5, data checksum) and gives
// one result item per input item: payload bytes with their index as they
// arrive, and a verdict on the trailer byte or at the first failed check. A
// restart item clears the exchange. Bytes past 64 per exchange are dropped.
// The block takes one item every cycle; a held result stalls the update, and
// the input is held off once the input register is also full. Each result is
// registered in the cycle after its item is taken, while the item sits in the
// input register and the per-byte state update feeds the result register.
module nfc_reader_ack_and_response_parser_top
  import nrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // data_byte, data_index, response_command,
                                      // response_length, zero fill
  output logic [2:0]  m_axis_tuser    // event_res
);

  in_link_t link;
  logic     take;
  result_t  res;

  nrp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  ('{opcode: s_axis_tuser, rx_byte: s_axis_tdata}),
    .link_o  (link),
    .take_i  (take)
  );

  nrp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .link_i   (link),
    .take_o   (take),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (res)
  );

  assign m_axis_tuser = res.event_res;
  assign m_axis_tdata = {4'b0000, res.response_length, res.response_command,
                         res.data_index, res.data_byte};

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> link.valid && m_axis_tvalid)
    else $error("input stalled with a free stage");

  a_len_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EV_GOOD |-> res.response_length == '0)
    else $error("length given without good frame");

  a_take_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> m_axis_tvalid)
    else $error("taken item gave no result");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the reader ack and response parser
// streams exchanges of received bytes through nfc_reader_ack_and_response_parser_top
// and checks every result item against an in-bench parser; depends on nrp_pkg
`timescale 1ns / 100ps

module testbench;
  import nrp_pkg::*;

  localparam int unsigned RX_TARGET = 800;
  localparam int unsigned HOLD_AT   = 300;
  localparam int unsigned HOLD_LEN  = 120;
  localparam int unsigned DRAIN_AT  = 700;
  localparam int unsigned QUIET_LO  = 450;
  localparam int unsigned QUIET_HI  = 600;
  localparam logic [7:0] ACK_SEQ [6] = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};

  typedef enum logic [1:0] {
    HUNT_ACK,
    IN_FRAME,
    EXCH_DONE
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // rx_byte
  logic        s_axis_tuser = 1'b0;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // data_byte, data_index, response_command,
                                      // response_length, zero fill
  logic [2:0]  m_axis_tuser;          // event_res

  item_t       rx_items[$];
  result_t     pending_events[$];
  int unsigned rx_taken = 0;
  int unsigned mismatches = 0;
  logic        item_taken = 1'b0;

  // parser state as the block should hold it
  parse_phase_e     phase_q;
  logic [WIN_W-1:0] win_q;
  int unsigned      win_fill_q;
  int unsigned      held_q;
  int unsigned      fpos_q;
  int unsigned      flen_q;
  logic [7:0]       dsum_q;
  logic [7:0]       cmd_q;

  wire quiet = (rx_taken >= QUIET_LO) && (rx_taken < QUIET_HI);

  nfc_reader_ack_and_response_parser_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic void clear_exchange();
    phase_q    = HUNT_ACK;
    win_q      = '0;
    win_fill_q = 0;
    held_q     = 0;
    fpos_q     = 0;
    flen_q     = 0;
    dsum_q     = 8'h00;
    cmd_q      = 8'h00;
  endfunction

  function automatic result_t track_byte(item_t it);
    result_t     r;
    int unsigned pos;
    logic [7:0]  b;
    r = '0;
    r.event_res = EV_CONSUMED;
    b = it.rx_byte;
    if (it.opcode == OP_RESTART) begin
      clear_exchange();
    end else if (held_q >= BUFFER_BYTES) begin
      r.event_res = EV_DROPPED;
    end else begin
      held_q++;
      if (phase_q == HUNT_ACK) begin
        if (win_fill_q >= 5 && win_q == ACK_HEAD && b == ACK_TAIL) begin
          r.event_res = EV_ACK;
          phase_q = IN_FRAME;
          fpos_q = 0;
        end
        win_q = {win_q[WIN_W-9:0], b};
        if (win_fill_q < 5) win_fill_q++;
      end else if (phase_q == IN_FRAME) begin
        pos = fpos_q;
        fpos_q = pos + 1;
        if (pos <= 1) begin
          if (b != START_BYTE) r.event_res = EV_BAD;
        end else if (pos == 2) begin
          if (b != START_CODE) r.event_res = EV_BAD;
        end else if (pos == 3) begin
          flen_q = b;
        end else if (pos == 4) begin
          if (8'(flen_q + b) != 8'h00) r.event_res = EV_BAD;
        end else if (pos == 5) begin
          if (b != DIR_TO_HOST) r.event_res = EV_BAD;
          else dsum_q = b;
        end else if (pos == flen_q + 6) begin
          if (flen_q >= 2 && dsum_q == 8'h00) begin
            r.event_res = EV_GOOD;
            r.response_length = IDX_W'(flen_q - 2);
          end else begin
            r.event_res = EV_BAD;
          end
        end else if (pos == flen_q + 5) begin
          dsum_q = dsum_q + b;
        end else begin
          dsum_q = dsum_q + b;
          if (pos == 6) begin
            cmd_q = b;
          end else begin
            r.event_res = EV_PAYLOAD;
            r.data_byte = b;
            r.data_index = IDX_W'(pos - 7);
          end
        end
        if (r.event_res == EV_GOOD || r.event_res == EV_BAD) phase_q = EXCH_DONE;
      end
    end
    r.response_command = cmd_q;
    return r;
  endfunction

  task automatic add_item(logic op, logic [7:0] b);
    item_t it;
    it.opcode = op;
    it.rx_byte = b;
    rx_items.push_back(it);
  endtask

  // optional restart, noise, acknowledge and response frame each with an optional fault, junk
  task automatic add_exchange();
    logic [7:0]  frm[$];
    logic [7:0]  sum;
    logic [7:0]  cmd;
    int unsigned len, n_pay, roll, k;
    if ($urandom_range(9) != 0) add_item(OP_RESTART, 8'($urandom));
    repeat ($urandom_range(3)) add_item(OP_BYTE, $urandom_range(1) ? 8'h00 : 8'($urandom));
    for (int i = 0; i < 6; i++) frm.push_back(ACK_SEQ[i]);
    if ($urandom_range(99) < 8) frm[$urandom_range(5)] ^= 8'($urandom_range(1, 255));
    roll = $urandom_range(99);
    if (roll < 6) len = $urandom_range(1);
    else if (roll < 12) len = $urandom_range(50, 255);
    else len = $urandom_range(2, 14);
    frm.push_back(START_BYTE);
    frm.push_back(START_BYTE);
    frm.push_back(START_CODE);
    frm.push_back(8'(len));
    frm.push_back(8'(0 - len));
    frm.push_back(DIR_TO_HOST);
    if (len >= 2) begin
      cmd = 8'($urandom);
      sum = DIR_TO_HOST + cmd;
      frm.push_back(cmd);
      n_pay = (len - 2 > 55) ? 55 : len - 2;
      repeat (n_pay) begin
        frm.push_back(8'($urandom));
        sum = sum + frm[$];
      end
      frm.push_back(8'h00 - sum);
      frm.push_back(8'($urandom));
    end else begin
      repeat (len + 1) frm.push_back(8'($urandom));
    end
    roll = $urandom_range(99);
    if (roll < 5) frm[6 + $urandom_range(2)] ^= 8'($urandom_range(1, 255));
    else if (roll < 10) frm[10] ^= 8'($urandom_range(1, 255));
    else if (roll < 15) frm[11] ^= 8'($urandom_range(1, 255));
    else if (roll < 22 && len >= 2) frm[frm.size() - 2] ^= 8'($urandom_range(1, 255));
    else if (roll < 27) begin
      k = $urandom_range(frm.size() - 1);
      while (frm.size() > k) void'(frm.pop_back());
    end
    foreach (frm[i]) add_item(OP_BYTE, frm[i]);
    repeat ($urandom_range(2)) add_item(OP_BYTE, 8'($urandom));
  endtask

  // accept side: predict each taken item
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_events.push_back(track_byte('{opcode: s_axis_tuser, rx_byte: s_axis_tdata}));
      void'(rx_items.pop_front());
      rx_taken <= rx_taken + 1;
      item_taken <= 1'b1;
    end else begin
      item_taken <= 1'b0;
    end
  end

  always @(negedge clk_i) begin : drive_rx
    bit gap;
    bit drain;
    gap = !quiet && ($urandom_range(99) < 12);
    drain = (rx_taken == DRAIN_AT) && (pending_events.size() != 0);
    if (rst_ni) begin
      if (s_axis_tvalid && !item_taken) begin
        // offered item still waiting
      end else if (rx_items.size() != 0 && !gap && !drain) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rx_items[0].opcode;
        s_axis_tdata <= rx_items[0].rx_byte;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_ready
    int unsigned hold_left;
    bit          hold_done;
    if (rst_ni) begin
      if (!hold_done && rx_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk_i) begin : check_events
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.event_res        = event_e'(m_axis_tuser);
      got.data_byte        = m_axis_tdata[7:0];
      got.data_index       = m_axis_tdata[13:8];
      got.response_command = m_axis_tdata[21:14];
      got.response_length  = m_axis_tdata[27:22];
      if (pending_events.size() == 0) begin
        $error("result item with none expected: event_res %0d", got.event_res);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (got.event_res != want.event_res) begin
          $error("event_res expected %0d actual %0d", want.event_res, got.event_res);
          mismatches++;
        end
        if (got.data_byte != want.data_byte) begin
          $error("data_byte expected %0d actual %0d", want.data_byte, got.data_byte);
          mismatches++;
        end
        if (got.data_index != want.data_index) begin
          $error("data_index expected %0d actual %0d", want.data_index, got.data_index);
          mismatches++;
        end
        if (got.response_command != want.response_command) begin
          $error("response_command expected %0d actual %0d",
                 want.response_command, got.response_command);
          mismatches++;
        end
        if (got.response_length != want.response_length) begin
          $error("response_length expected %0d actual %0d",
                 want.response_length, got.response_length);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clear_exchange();
    // good frame with noise before the acknowledge, length two, command ff
    add_item(OP_RESTART, 8'hFF);
    add_item(OP_BYTE, 8'h00);
    foreach (ACK_SEQ[i]) add_item(OP_BYTE, ACK_SEQ[i]);
    add_item(OP_BYTE, START_BYTE);
    add_item(OP_BYTE, START_BYTE);
    add_item(OP_BYTE, START_CODE);
    add_item(OP_BYTE, 8'h02);
    add_item(OP_BYTE, 8'hFE);
    add_item(OP_BYTE, DIR_TO_HOST);
    add_item(OP_BYTE, 8'hFF);
    add_item(OP_BYTE, 8'h2C);
    add_item(OP_BYTE, 8'h00);
    // bad start byte, then a byte after the verdict
    add_item(OP_RESTART, 8'h00);
    foreach (ACK_SEQ[i]) add_item(OP_BYTE, ACK_SEQ[i]);
    add_item(OP_BYTE, 8'h01);
    add_item(OP_BYTE, 8'hFF);
    while (rx_items.size() < RX_TARGET) add_exchange();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (rx_items.size() != 0 || pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
